/* src/ttr_pkg.sv */
// transposition table replace: shared types, opcodes and controller interface
// used by ttr_ctrl, ttr_datapath and transposition_table_replace
// no dependencies
`timescale 1ns / 1ps

package ttr_pkg;

   // field widths
   localparam int KEY_W     = 64;
   localparam int KEY_MSB   = 63;
   localparam int CFG_W     = 13;
   localparam int DIV_CNT_W = 6;

   // entry count after reset
   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   // operation codes
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_PROBE = 2'd0;
   localparam opcode_type OP_SAVE  = 2'd1;
   localparam opcode_type OP_AGE   = 2'd2;
   localparam opcode_type OP_NOP   = 2'd3;

   // bound type that always replaces
   localparam logic [1:0] BTYPE_FORCE = 2'd0;

   // one table slot, age mark kept apart
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic signed [15:0] score;
      logic [1:0]         btype;
      logic [15:0]        move;
      logic [7:0]         depth;
   } ttr_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_DIVIDE,
      ST_READ,
      ST_LOOKUP,
      ST_AGE,
      ST_RESPOND
   } ttr_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic zero_result;
      logic div_start;
      logic div_step;
      logic mem_read;
      logic lookup;
      logic sweep_start;
      logic sweep_clear;
      logic sweep_age;
      logic out_load;
   } ttr_cmd_type;

   // datapath to controller
   typedef struct packed {
      opcode_type opcode;
      logic       table_off;
      logic       div_last;
      logic       sweep_last;
      logic       out_free;
   } ttr_status_type;

endpackage

/* src/transposition_table_replace.sv */
// transposition table replace: top level joining controller and datapath
// depends on ttr_pkg, ttr_ctrl and ttr_datapath
//
//   port group   direction   contents
//   req_*        in          opcode, key, score, bound type, move, depth, pv flag
//   rsp_*        out         stored key, score, type, move, depth, written flag
//   csr_*        in          entries_in_use write (13 bits), no read-back
//
// probe and save first take the one-bit-per-cycle remainder of the key by the
// entry count, then read the slot, apply the replacement rule and respond.
// age marks the slots up to the entry count in use (capped at TABLE_ENTRIES),
// one slot's age mark written per cycle.
// unknown opcode or a disabled table goes straight to the response with zeros.
// after reset a clearing pass over all TABLE_ENTRIES slots holds req_stall high.
// one transaction is in work at a time; the next is taken while the previous
// result waits in the output register under rsp_stall.
`timescale 1ns / 1ps

module transposition_table_replace #(
   parameter int unsigned TABLE_ENTRIES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_opcode,
   input  logic [63:0]               req_key,
   input  logic signed [15:0]        req_score,
   input  logic [1:0]                req_bound_type,
   input  logic [15:0]               req_best_move,
   input  logic [7:0]                req_search_depth,
   input  logic                      req_principal_node,
   input  logic                      csr_wr_en,
   input  logic [12:0]               csr_wr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [63:0]               rsp_stored_key,
   output logic signed [15:0]        rsp_stored_score,
   output logic [1:0]                rsp_stored_type,
   output logic [15:0]               rsp_stored_move,
   output logic [7:0]                rsp_stored_depth,
   output logic                      rsp_written
);

   ttr_pkg::ttr_cmd_type    cmd;
   ttr_pkg::ttr_status_type status;

   // sequencing
   ttr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   ttr_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_opcode),
      .req_key            (req_key),
      .req_score          (req_score),
      .req_bound_type     (req_bound_type),
      .req_best_move      (req_best_move),
      .req_search_depth   (req_search_depth),
      .req_principal_node (req_principal_node),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stored_key     (rsp_stored_key),
      .rsp_stored_score   (rsp_stored_score),
      .rsp_stored_type    (rsp_stored_type),
      .rsp_stored_move    (rsp_stored_move),
      .rsp_stored_depth   (rsp_stored_depth),
      .rsp_written        (rsp_written)
   );

   // a save result never carries slot contents
   a_written_has_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_written |-> rsp_stored_key == 64'd0 &&
                                   rsp_stored_depth == 8'd0)
      else $error("save result carries slot contents");

   // one transaction in work: an accept is followed by stall
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction accepted while one is in work");

   // output register is never overwritten while held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid || !rsp_stall)
      else $error("output register overwritten under stall");

   // a new result appears only through an output load
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result valid without output load");

endmodule

/* src/ttr_ctrl.sv */
// transposition table replace: sequencing state machine
// depends on ttr_pkg for state, command and status types
`timescale 1ns / 1ps

module ttr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ttr_pkg::ttr_status_type status,
   output ttr_pkg::ttr_cmd_type    cmd
);

   ttr_pkg::ttr_state_type state_ff;
   ttr_pkg::ttr_state_type state_in;

   // state register, clearing pass runs first after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ttr_pkg::ST_CLEAR: begin
            cmd.sweep_clear = 1'b1;
            if (status.sweep_last) begin
               state_in = ttr_pkg::ST_IDLE;
            end
         end
         ttr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ttr_pkg::ST_DISPATCH;
            end
         end
         ttr_pkg::ST_DISPATCH: begin
            if (status.table_off) begin
               cmd.zero_result = 1'b1;
               state_in        = ttr_pkg::ST_RESPOND;
            end else begin
               unique case (status.opcode) inside
                  ttr_pkg::OP_PROBE, ttr_pkg::OP_SAVE: begin
                     cmd.div_start = 1'b1;
                     state_in      = ttr_pkg::ST_DIVIDE;
                  end
                  ttr_pkg::OP_AGE: begin
                     cmd.zero_result = 1'b1;
                     cmd.sweep_start = 1'b1;
                     state_in        = ttr_pkg::ST_AGE;
                  end
                  default: begin
                     cmd.zero_result = 1'b1;
                     state_in        = ttr_pkg::ST_RESPOND;
                  end
               endcase
            end
         end
         ttr_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ttr_pkg::ST_READ;
            end
         end
         ttr_pkg::ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ttr_pkg::ST_LOOKUP;
         end
         ttr_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ttr_pkg::ST_RESPOND;
         end
         ttr_pkg::ST_AGE: begin
            cmd.sweep_age = 1'b1;
            if (status.sweep_last) begin
               state_in = ttr_pkg::ST_RESPOND;
            end
         end
         ttr_pkg::ST_RESPOND: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ttr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* src/ttr_datapath.sv */
// transposition table replace: item registers, remainder unit, slot memories,
// replacement decision and output register; depends on ttr_pkg
`timescale 1ns / 1ps

module ttr_datapath #(
   parameter int unsigned TABLE_ENTRIES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ttr_pkg::ttr_cmd_type                 cmd,
   output ttr_pkg::ttr_status_type              status,
   input  logic [1:0]                           req_opcode,
   input  logic [ttr_pkg::KEY_W-1:0]            req_key,
   input  logic signed [15:0]                   req_score,
   input  logic [1:0]                           req_bound_type,
   input  logic [15:0]                          req_best_move,
   input  logic [7:0]                           req_search_depth,
   input  logic                                 req_principal_node,
   input  logic                                 csr_wr_en,
   input  logic [ttr_pkg::CFG_W-1:0]            csr_wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ttr_pkg::KEY_W-1:0]            rsp_stored_key,
   output logic signed [15:0]                   rsp_stored_score,
   output logic [1:0]                           rsp_stored_type,
   output logic [15:0]                          rsp_stored_move,
   output logic [7:0]                           rsp_stored_depth,
   output logic                                 rsp_written
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int CNTC_W = $clog2(TABLE_ENTRIES + 1);
   localparam int CNT_W  = (CNTC_W > ttr_pkg::CFG_W) ? CNTC_W : ttr_pkg::CFG_W;
   localparam logic [CNT_W-1:0] TABLE_COUNT = CNT_W'(TABLE_ENTRIES);
   localparam logic [ttr_pkg::DIV_CNT_W-1:0] DIV_LAST =
      ttr_pkg::DIV_CNT_W'(ttr_pkg::KEY_MSB);

   // configuration
   logic [ttr_pkg::CFG_W-1:0] cfg_ff;
   logic [CNT_W-1:0]          cfg_count;

   // latched transaction
   ttr_pkg::opcode_type       op_ff;
   ttr_pkg::ttr_entry_type    item_ff;
   logic                      pv_ff;
   logic [CNT_W-1:0]          n_ff;
   logic [CNT_W-1:0]          n_in;

   // remainder unit
   logic [ttr_pkg::KEY_W-1:0]     div_key_ff;
   logic [ttr_pkg::KEY_W-1:0]     div_key_in;
   logic [ttr_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [ttr_pkg::DIV_CNT_W-1:0] div_cnt_in;
   logic [CNT_W-1:0]              rem_ff;
   logic [CNT_W-1:0]              rem_in;
   logic [CNT_W:0]                rem_shift;
   logic [CNT_W:0]                rem_diff;
   logic [IDX_W-1:0]              slot_idx;

   // sweep counter for clearing and aging
   logic [IDX_W-1:0] sweep_ff;
   logic [IDX_W-1:0] sweep_in;
   logic [CNT_W-1:0] sweep_limit;

   // slot memories
   ttr_pkg::ttr_entry_type data_mem [TABLE_ENTRIES];
   logic                   aged_mem [TABLE_ENTRIES];
   ttr_pkg::ttr_entry_type rd_entry_ff;
   logic                   rd_aged_ff;
   logic                   data_we;
   logic                   aged_we;
   logic [IDX_W-1:0]       mem_waddr;
   ttr_pkg::ttr_entry_type data_wdata;
   logic                   aged_wdata;

   // replacement decision
   logic key_match;
   logic do_write;

   // result and output registers
   ttr_pkg::ttr_entry_type res_entry_ff;
   ttr_pkg::ttr_entry_type res_entry_in;
   logic                   res_written_ff;
   logic                   res_written_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   ttr_pkg::ttr_entry_type rsp_entry_ff;
   logic                   rsp_written_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ttr_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         cfg_ff <= csr_wr_data;
      end
   end

   // saturate the entry count at the table size
   assign cfg_count = CNT_W'(cfg_ff);
   assign n_in      = (cfg_count > TABLE_COUNT) ? TABLE_COUNT : cfg_count;

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff         <= req_opcode;
         item_ff.key   <= req_key;
         item_ff.score <= req_score;
         item_ff.btype <= req_bound_type;
         item_ff.move  <= req_best_move;
         item_ff.depth <= req_search_depth;
         pv_ff         <= req_principal_node;
         n_ff          <= n_in;
      end
   end

   // restoring remainder, one key bit per cycle, msb first
   assign rem_shift = {rem_ff, div_key_ff[ttr_pkg::KEY_MSB]};
   assign rem_diff  = rem_shift - {1'b0, n_ff};
   assign slot_idx  = rem_ff[IDX_W-1:0];

   always_comb begin
      div_key_in = div_key_ff;
      div_cnt_in = div_cnt_ff;
      rem_in     = rem_ff;
      if (cmd.div_start) begin
         div_key_in = item_ff.key;
         div_cnt_in = '0;
         rem_in     = '0;
      end else if (cmd.div_step) begin
         div_key_in = {div_key_ff[ttr_pkg::KEY_MSB-1:0], 1'b0};
         div_cnt_in = div_cnt_ff + 1'b1;
         rem_in     = (rem_shift >= {1'b0, n_ff}) ? rem_diff[CNT_W-1:0]
                                                  : rem_shift[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      div_key_ff <= div_key_in;
      div_cnt_ff <= div_cnt_in;
      rem_ff     <= rem_in;
   end

   // sweep counter
   assign sweep_limit = cmd.sweep_clear ? TABLE_COUNT : n_ff;

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_start) begin
         sweep_in = '0;
      end else if (cmd.sweep_clear || cmd.sweep_age) begin
         sweep_in = sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   // replacement rule
   assign key_match = (rd_entry_ff.key == item_ff.key);
   assign do_write  = (item_ff.btype == ttr_pkg::BTYPE_FORCE) || pv_ff ||
                      (rd_aged_ff && !key_match) ||
                      !(rd_entry_ff.depth > item_ff.depth);

   // memory write port selection
   always_comb begin
      data_we    = 1'b0;
      aged_we    = 1'b0;
      mem_waddr  = slot_idx;
      data_wdata = item_ff;
      aged_wdata = 1'b0;
      if (cmd.sweep_clear) begin
         data_we    = 1'b1;
         aged_we    = 1'b1;
         mem_waddr  = sweep_ff;
         data_wdata = '0;
         aged_wdata = 1'b1;
      end else if (cmd.sweep_age) begin
         aged_we    = 1'b1;
         mem_waddr  = sweep_ff;
         aged_wdata = 1'b1;
      end else if (cmd.lookup) begin
         case (op_ff)
            ttr_pkg::OP_PROBE: aged_we = key_match;
            ttr_pkg::OP_SAVE: begin
               data_we = do_write;
               aged_we = do_write;
            end
            default: aged_we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[mem_waddr] <= data_wdata;
      end
      if (aged_we) begin
         aged_mem[mem_waddr] <= aged_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_entry_ff <= data_mem[slot_idx];
         rd_aged_ff  <= aged_mem[slot_idx];
      end
   end

   // result of the transaction
   always_comb begin
      res_entry_in   = res_entry_ff;
      res_written_in = res_written_ff;
      if (cmd.zero_result) begin
         res_entry_in   = '0;
         res_written_in = 1'b0;
      end else if (cmd.lookup) begin
         res_entry_in   = (op_ff == ttr_pkg::OP_PROBE) ? rd_entry_ff : '0;
         res_written_in = (op_ff == ttr_pkg::OP_SAVE) && do_write;
      end
   end

   always_ff @(posedge clock) begin
      res_entry_ff   <= res_entry_in;
      res_written_ff <= res_written_in;
   end

   // output register
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_entry_ff   <= res_entry_ff;
         rsp_written_ff <= res_written_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_stored_key   = rsp_entry_ff.key;
   assign rsp_stored_score = rsp_entry_ff.score;
   assign rsp_stored_type  = rsp_entry_ff.btype;
   assign rsp_stored_move  = rsp_entry_ff.move;
   assign rsp_stored_depth = rsp_entry_ff.depth;
   assign rsp_written      = rsp_written_ff;

   // status to controller
   assign status.opcode     = op_ff;
   assign status.table_off  = (n_ff == '0);
   assign status.div_last   = (div_cnt_ff == DIV_LAST);
   assign status.sweep_last = (CNT_W'(sweep_ff) == (sweep_limit - CNT_W'(1)));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

/* sim/tb_transposition_table_replace.sv */
// testbench for transposition_table_replace: directed and random probe, save and age
// transactions checked field by field against a slot-level table model in a scoreboard class
// depends on ttr_pkg and the transposition_table_replace rtl
`timescale 1ns / 1ps

module tb_transposition_table_replace;

   localparam int SLOTS       = 4096;
   // slowest legal run, including the clearing pass, stays well under the limit
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int PHASE_ITEMS = 70;

   typedef struct {
      ttr_pkg::opcode_type opcode;
      logic [63:0]         key;
      logic signed [15:0]  score;
      logic [1:0]          btype;
      logic [15:0]         move;
      logic [7:0]          depth;
      logic                pv;
   } tt_request_type;

   typedef struct packed {
      ttr_pkg::ttr_entry_type entry;
      logic                   written;
   } tt_result_type;

   // table model: slot contents, age marks, entry count and results still owed
   class slot_tracker;
      ttr_pkg::ttr_entry_type slots[SLOTS];
      bit                     aged[SLOTS];
      logic [12:0]            entries_in_use;
      tt_result_type          expected_results[$];
      int                     mismatches;

      function new();
         foreach (slots[i]) begin
            slots[i] = '0;
            aged[i]  = 1'b1;
         end
         entries_in_use = ttr_pkg::CFG_RESET;
         mismatches     = 0;
      endfunction

      function void set_entries(logic [12:0] value);
         entries_in_use = value;
      endfunction

      // update the slots for one accepted transaction and queue its result
      function void note_request(tt_request_type r);
         logic [63:0]   span;
         int            idx;
         int            i;
         bit            replace;
         tt_result_type res;
         res  = '0;
         span = (entries_in_use > SLOTS) ? 64'(SLOTS) : 64'(entries_in_use);
         if (span != 0) begin
            case (r.opcode)
               ttr_pkg::OP_AGE: begin
                  for (i = 0; i < span; i++)
                     aged[i] = 1'b1;
               end
               ttr_pkg::OP_PROBE: begin
                  idx = int'(r.key % span);
                  if (slots[idx].key == r.key)
                     aged[idx] = 1'b0;
                  res.entry = slots[idx];
               end
               ttr_pkg::OP_SAVE: begin
                  idx = int'(r.key % span);
                  // depth-preferred rule with forced and aged replacement
                  replace = (r.btype == ttr_pkg::BTYPE_FORCE) || r.pv ||
                            (aged[idx] && slots[idx].key != r.key) ||
                            (slots[idx].depth <= r.depth);
                  if (replace) begin
                     slots[idx].key   = r.key;
                     slots[idx].score = r.score;
                     slots[idx].btype = r.btype;
                     slots[idx].move  = r.move;
                     slots[idx].depth = r.depth;
                     aged[idx]        = 1'b0;
                     res.written      = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         expected_results.push_back(res);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // compare one accepted result with the oldest expectation
      function void check_result(tt_result_type got);
         tt_result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: result with no transaction outstanding, actual %h", $time, got);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            compare_field("stored_key", want.entry.key, got.entry.key);
            compare_field("stored_score", want.entry.score, got.entry.score);
            compare_field("stored_type", want.entry.btype, got.entry.btype);
            compare_field("stored_move", want.entry.move, got.entry.move);
            compare_field("stored_depth", want.entry.depth, got.entry.depth);
            compare_field("written", want.written, got.written);
         end
      endfunction
   endclass

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode         = ttr_pkg::OP_NOP;
   logic [63:0]        req_key            = '0;
   logic signed [15:0] req_score          = '0;
   logic [1:0]         req_bound_type     = '0;
   logic [15:0]        req_best_move      = '0;
   logic [7:0]         req_search_depth   = '0;
   logic               req_principal_node = 1'b0;
   logic               csr_wr_en          = 1'b0;
   logic [12:0]        csr_wr_data        = '0;
   logic               rsp_valid;
   logic               rsp_stall          = 1'b0;
   logic [63:0]        rsp_stored_key;
   logic signed [15:0] rsp_stored_score;
   logic [1:0]         rsp_stored_type;
   logic [15:0]        rsp_stored_move;
   logic [7:0]         rsp_stored_depth;
   logic               rsp_written;

   slot_tracker tracker;
   bit          calm   = 1'b0;
   int          cycles = 0;

   transposition_table_replace uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_key            (req_key),
      .req_score          (req_score),
      .req_bound_type     (req_bound_type),
      .req_best_move      (req_best_move),
      .req_search_depth   (req_search_depth),
      .req_principal_node (req_principal_node),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stored_key     (rsp_stored_key),
      .rsp_stored_score   (rsp_stored_score),
      .rsp_stored_type    (rsp_stored_type),
      .rsp_stored_move    (rsp_stored_move),
      .rsp_stored_depth   (rsp_stored_depth),
      .rsp_written        (rsp_written)
   );

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: check each accepted transaction, stall at random
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.check_result(tt_result_type'({rsp_stored_key, rsp_stored_score,
                                                  rsp_stored_type, rsp_stored_move,
                                                  rsp_stored_depth, rsp_written}));
         rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 14);
      end
   end

   function automatic tt_request_type make_request(ttr_pkg::opcode_type op,
                                                   logic [63:0] key,
                                                   logic signed [15:0] score,
                                                   logic [1:0] btype,
                                                   logic [15:0] move, logic [7:0] depth,
                                                   logic pv);
      tt_request_type r;
      r.opcode = op;
      r.key    = key;
      r.score  = score;
      r.btype  = btype;
      r.move   = move;
      r.depth  = depth;
      r.pv     = pv;
      return r;
   endfunction

   // drive one transaction, with a random gap first, and hold it until taken
   task automatic send_request(tt_request_type r);
      if (!calm) begin
         if ($urandom_range(0, 99) < 3) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clock);
         end
         while ($urandom_range(0, 99) < 14) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid          <= 1'b1;
      req_opcode         <= r.opcode;
      req_key            <= r.key;
      req_score          <= r.score;
      req_bound_type     <= r.btype;
      req_best_move      <= r.move;
      req_search_depth   <= r.depth;
      req_principal_node <= r.pv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(r);
   endtask

   // hold off the sender until every owed result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_entries(logic [12:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tracker.set_entries(value);
      csr_wr_en <= 1'b0;
   endtask

   // random traffic over a small key pool so slots collide and keys recur
   task automatic run_random(int count);
      logic [63:0]    pool[8];
      logic [63:0]    span;
      logic [63:0]    base;
      logic [63:0]    last_key;
      tt_request_type r;
      int             sel;
      int             k;
      span = (tracker.entries_in_use > SLOTS) ? 64'(SLOTS) : 64'(tracker.entries_in_use);
      if (span == 0)
         span = 64'd1;
      base = {$urandom, $urandom};
      for (k = 0; k < 6; k++)
         pool[k] = base + 64'(k) * span;
      pool[6]  = '0;
      pool[7]  = '1;
      last_key = pool[0];
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 44)
            r.opcode = ttr_pkg::OP_PROBE;
         else if (sel < 92)
            r.opcode = ttr_pkg::OP_SAVE;
         else if (sel < 96 && (span <= 512 || $urandom_range(0, 9) == 0))
            r.opcode = ttr_pkg::OP_AGE;
         else
            r.opcode = ttr_pkg::OP_NOP;
         sel = $urandom_range(0, 9);
         if (sel < 4)
            r.key = last_key;
         else if (sel < 8)
            r.key = pool[$urandom_range(0, 7)];
         else
            r.key = {$urandom, $urandom};
         r.score  = 16'($urandom);
         r.btype  = 2'($urandom_range(0, 3));
         r.move   = 16'($urandom);
         r.depth  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 15));
         r.pv     = ($urandom_range(0, 99) < 12);
         last_key = r.key;
         if ($urandom_range(0, 99) == 0)
            wait_drain();
         send_request(r);
      end
   endtask

   initial begin
      logic [63:0] ones;
      logic [63:0] collide;
      logic [12:0] settings[9];
      int          p;
      tracker  = new();
      ones     = '1;
      // same slot as ones while 4096 entries are in use
      collide  = ones - 64'd4096;
      settings = '{13'd8191, 13'd1, 13'd3, 13'd4096, 13'd0, 13'd64, 13'd4095, 13'd2, 13'd777};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_entries(13'd4096);

      // fresh table: key zero matches the cleared slot, a colliding key does not
      send_request(make_request(ttr_pkg::OP_PROBE, 64'd0, 16'sd0, 2'd0, 16'd0, 8'd0, 1'b0));
      send_request(make_request(ttr_pkg::OP_PROBE, 64'd4096, 16'sd0, 2'd3, 16'd0, 8'd0, 1'b0));
      // aged slot with a different key is taken at any depth
      send_request(make_request(ttr_pkg::OP_SAVE, ones, -16'sd32768, 2'd1, 16'hFFFF, 8'd255,
                                1'b0));
      send_request(make_request(ttr_pkg::OP_PROBE, ones, 16'sd0, 2'd0, 16'd0, 8'd0, 1'b0));
      // deeper entry kept, equal depth replaces
      send_request(make_request(ttr_pkg::OP_SAVE, ones, 16'sd32767, 2'd2, 16'h1234, 8'd10,
                                1'b0));
      send_request(make_request(ttr_pkg::OP_SAVE, ones, 16'sd1, 2'd3, 16'h00FF, 8'd255, 1'b0));
      // bound type zero and pv node replace regardless of depth
      send_request(make_request(ttr_pkg::OP_SAVE, ones, -16'sd1, 2'd0, 16'd1, 8'd0, 1'b0));
      send_request(make_request(ttr_pkg::OP_SAVE, ones, 16'sd2, 2'd1, 16'd2, 8'd200, 1'b0));
      send_request(make_request(ttr_pkg::OP_SAVE, ones, 16'sd3, 2'd2, 16'd3, 8'd100, 1'b1));
      // colliding key skipped while the slot is fresh, taken once aged
      send_request(make_request(ttr_pkg::OP_SAVE, collide, 16'sd5, 2'd1, 16'd5, 8'd3, 1'b0));
      send_request(make_request(ttr_pkg::OP_AGE, 64'd0, 16'sd0, 2'd0, 16'd0, 8'd0, 1'b0));
      send_request(make_request(ttr_pkg::OP_SAVE, collide, 16'sd6, 2'd1, 16'd6, 8'd3, 1'b0));
      send_request(make_request(ttr_pkg::OP_PROBE, ones, 16'sd0, 2'd0, 16'd0, 8'd0, 1'b0));
      // probe hit clears the age mark, so a shallower foreign save is skipped
      send_request(make_request(ttr_pkg::OP_AGE, ones, -16'sd1, 2'd3, 16'hFFFF, 8'd255, 1'b1));
      send_request(make_request(ttr_pkg::OP_PROBE, collide, 16'sd0, 2'd0, 16'd0, 8'd0, 1'b0));
      send_request(make_request(ttr_pkg::OP_SAVE, ones, 16'sd7, 2'd1, 16'd7, 8'd0, 1'b0));
      // unknown opcode changes nothing
      send_request(make_request(ttr_pkg::OP_NOP, ones, -16'sd1, 2'd3, 16'hFFFF, 8'd255, 1'b1));
      send_request(make_request(ttr_pkg::OP_PROBE, collide, 16'sd0, 2'd0, 16'd0, 8'd0, 1'b0));

      // disabled table: every transaction returns zeros and changes nothing
      wait_drain();
      write_entries(13'd0);
      send_request(make_request(ttr_pkg::OP_SAVE, ones, 16'sd9, 2'd0, 16'd9, 8'd9, 1'b1));
      send_request(make_request(ttr_pkg::OP_AGE, 64'd0, 16'sd0, 2'd0, 16'd0, 8'd0, 1'b0));
      send_request(make_request(ttr_pkg::OP_PROBE, collide, 16'sd0, 2'd0, 16'd0, 8'd0, 1'b0));
      send_request(make_request(ttr_pkg::OP_NOP, 64'd0, 16'sd0, 2'd0, 16'd0, 8'd0, 1'b0));

      // random phases over several entry counts, one of them without idling
      for (p = 0; p < 9; p++) begin
         wait_drain();
         write_entries(settings[p]);
         calm = (p == 3);
         run_random((settings[p] == 0) ? 20 : PHASE_ITEMS);
      end
      calm = 1'b0;

      wait_drain();
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
